@@ design/pdll_pkg.sv @@
// Package: request codes, status codes and cursor modes for the list manager.
package pdll_pkg;
  localparam logic [3:0] OP_CREATE  = 4'd0;
  localparam logic [3:0] OP_COUNT   = 4'd1;
  localparam logic [3:0] OP_FIRST   = 4'd2;
  localparam logic [3:0] OP_LAST    = 4'd3;
  localparam logic [3:0] OP_NEXT    = 4'd4;
  localparam logic [3:0] OP_PREV    = 4'd5;
  localparam logic [3:0] OP_CURR    = 4'd6;
  localparam logic [3:0] OP_ADD     = 4'd7;
  localparam logic [3:0] OP_INSERT  = 4'd8;
  localparam logic [3:0] OP_APPEND  = 4'd9;
  localparam logic [3:0] OP_PREPEND = 4'd10;
  localparam logic [3:0] OP_REMOVE  = 4'd11;
  localparam logic [3:0] OP_CONCAT  = 4'd12;
  localparam logic [3:0] OP_FREE    = 4'd13;
  localparam logic [3:0] OP_TRIM    = 4'd14;
  localparam logic [3:0] OP_SEARCH  = 4'd15;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EXHAUST = 2'd1;
  localparam logic [1:0] ST_NOITEM  = 2'd2;

  localparam logic [1:0] MODE_ON     = 2'd0;
  localparam logic [1:0] MODE_BEFORE = 2'd1;
  localparam logic [1:0] MODE_BEYOND = 2'd2;
endpackage

@@ design/pooled_doubly_linked_list_manager.sv @@
// Top level: pooled doubly linked list manager with node and handle free stacks.
//
// Usage: one request word enters on in_* (tdata: req_type, list_id,
// other_list_id, item_value from bit 0 up) and gives exactly one result word
// on out_* (tdata: status, item_valid, result_item, new_handle, item_count).
// Requests are handled one at a time. The node fields live in three
// synchronous RAMs (item, next, prev) with registered reads; list
// records and the handle stack are registers.
// Free and search walk the list node by node, as each step waits on one
// next-pointer read.
// Reset clears list records, stacks and control; the next RAM holds
// a free chain which a clearing pass over every node lays down after
// reset, during which in_tready stays low.
// When the receiver stalls, the result is held in the output register and
// no new request is taken until it is delivered.
module pooled_doubly_linked_list_manager
  import pdll_pkg::*;
#(
  parameter int NUM_NODES  = 64,
  parameter int NUM_LISTS  = 8,
  parameter int ITEM_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // req_type[3:0], list_id, other_list_id, item_value, zero fill
  input  logic [((4 + 2*$clog2(NUM_LISTS) + ITEM_WIDTH + 7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // status[1:0], item_valid, result_item, new_handle, item_count, zero fill
  output logic [((3 + ITEM_WIDTH + $clog2(NUM_LISTS) + $clog2(NUM_NODES+1) + 7)/8)*8-1:0]
    out_tdata
);
  localparam int NW = $clog2(NUM_NODES + 1);
  localparam int AW = $clog2(NUM_NODES);
  localparam int HW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int HN = $clog2(NUM_LISTS + 1);
  localparam int LW = $clog2(NUM_LISTS);
  localparam logic [NW-1:0] NIL = NW'(NUM_NODES);
  localparam logic [HN-1:0] HNIL = HN'(NUM_LISTS);

  localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_RD1 = 4'd2, S_W1 = 4'd3,
    S_RD2 = 4'd4, S_W2 = 4'd5, S_WALK = 4'd6, S_WWAIT = 4'd7, S_OUT = 4'd8,
    S_RD3 = 4'd9, S_W3 = 4'd10;

  logic [ITEM_WIDTH-1:0] m_item [NUM_NODES];
  logic [NW-1:0] m_next [NUM_NODES];
  logic [NW-1:0] m_prev [NUM_NODES];
  logic [ITEM_WIDTH-1:0] rd_item;
  logic [NW-1:0] rd_next, rd_prev;
  logic [AW-1:0] ra, wa;
  logic we_item, we_next, we_prev;
  logic [ITEM_WIDTH-1:0] wd_item;
  logic [NW-1:0] wd_next, wd_prev;

  logic [NW-1:0] lf_r [NUM_LISTS], lf_nxt [NUM_LISTS];
  logic [NW-1:0] ll_r [NUM_LISTS], ll_nxt [NUM_LISTS];
  logic [NW-1:0] cn_r [NUM_LISTS], cn_nxt [NUM_LISTS];
  logic [1:0] cm_r [NUM_LISTS], cm_nxt [NUM_LISTS];
  logic [NW-1:0] sz_r [NUM_LISTS], sz_nxt [NUM_LISTS];
  logic [HN-1:0] fh_r [NUM_LISTS], fh_nxt [NUM_LISTS];
  logic [HN-1:0] fht_r, fht_nxt;
  logic [NW-1:0] fnt_r, fnt_nxt;
  logic [3:0] st_r, st_nxt;
  logic [NW-1:0] ic_r, ic_nxt;
  logic [3:0] op_r, op_nxt;
  logic [HW-1:0] h_r, h_nxt, g_r, g_nxt;
  logic [ITEM_WIDTH-1:0] v_r, v_nxt;
  logic [NW-1:0] n_r, n_nxt, p_r, p_nxt, q_r, q_nxt;
  logic [NW-1:0] steps_r, steps_nxt;
  logic [1:0] ost_r, ost_nxt;
  logic oval_r, oval_nxt;
  logic [ITEM_WIDTH-1:0] oitem_r, oitem_nxt;
  logic [HW-1:0] ohd_r, ohd_nxt;
  logic [NW-1:0] ocnt_r, ocnt_nxt;
  logic [1:0] kind;
  logic [HW-1:0] in_h, in_g;
  logic [3:0] in_op;

  always_ff @(posedge clk) begin
    if (we_item) m_item[wa] <= wd_item;
    if (we_next) m_next[wa] <= wd_next;
    if (we_prev) m_prev[wa] <= wd_prev;
    rd_item <= m_item[ra];
    rd_next <= m_next[ra];
    rd_prev <= m_prev[ra];
  end

  function automatic logic isn(input logic [NW-1:0] x);
    return x < NIL;
  endfunction

  assign in_op = in_tdata[3:0];
  generate
    if (NUM_LISTS > 1) begin : g_h
      assign in_h = in_tdata[4 +: HW];
      assign in_g = in_tdata[4 + LW +: HW];
    end else begin : g_h1
      assign in_h = 1'b0;
      assign in_g = 1'b0;
    end
  endgenerate

  assign in_tready = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  always_comb begin
    out_tdata = '0;
    out_tdata[1:0] = ost_r;
    out_tdata[2] = oval_r;
    out_tdata[3 +: ITEM_WIDTH] = oitem_r;
    if (LW > 0) out_tdata[3 + ITEM_WIDTH +: HW] = ohd_r;
    out_tdata[3 + ITEM_WIDTH + LW +: NW] = ocnt_r;
  end

  always_comb begin
    if (cm_r[h_r] == MODE_BEFORE) kind = MODE_BEFORE;
    else if (cm_r[h_r] != MODE_ON) kind = MODE_BEYOND;
    else if (!isn(cn_r[h_r]) && isn(lf_r[h_r])) kind = MODE_BEYOND;
    else kind = MODE_ON;
  end

  always_comb begin
    lf_nxt = lf_r; ll_nxt = ll_r; cn_nxt = cn_r; cm_nxt = cm_r; sz_nxt = sz_r;
    fh_nxt = fh_r; fht_nxt = fht_r; fnt_nxt = fnt_r; st_nxt = st_r; ic_nxt = ic_r;
    op_nxt = op_r; h_nxt = h_r; g_nxt = g_r; v_nxt = v_r;
    n_nxt = n_r; p_nxt = p_r; q_nxt = q_r; steps_nxt = steps_r;
    ost_nxt = ost_r; oval_nxt = oval_r; oitem_nxt = oitem_r; ohd_nxt = ohd_r;
    ocnt_nxt = ocnt_r;
    ra = '0; wa = '0; we_item = 1'b0; we_next = 1'b0; we_prev = 1'b0;
    wd_item = '0; wd_next = NIL; wd_prev = NIL;
    case (st_r)
      S_INIT: begin
        wa = ic_r[AW-1:0]; we_next = 1'b1; we_prev = 1'b1; we_item = 1'b1;
        wd_next = (ic_r == '0) ? NIL : ic_r - 1'b1;
        ic_nxt = ic_r + 1'b1;
        if (ic_r == NW'(NUM_NODES - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt = in_op; h_nxt = in_h; g_nxt = in_g;
          v_nxt = in_tdata[4 + 2*LW +: ITEM_WIDTH];
          ost_nxt = ST_OK; oval_nxt = 1'b0; oitem_nxt = '0; ohd_nxt = '0;
          st_nxt = S_RD1;
        end
      end
      S_RD1: begin
        st_nxt = S_OUT;
        case (op_r)
          OP_CREATE: begin
            if (fht_r >= HNIL) ost_nxt = ST_EXHAUST;
            else begin
              fht_nxt = fh_r[fht_r[HW-1:0]];
              fh_nxt[fht_r[HW-1:0]] = HNIL;
              lf_nxt[fht_r[HW-1:0]] = NIL; ll_nxt[fht_r[HW-1:0]] = NIL;
              cn_nxt[fht_r[HW-1:0]] = NIL; cm_nxt[fht_r[HW-1:0]] = MODE_ON;
              sz_nxt[fht_r[HW-1:0]] = '0;
              ohd_nxt = fht_r[HW-1:0]; h_nxt = fht_r[HW-1:0];
            end
          end
          OP_COUNT: ;
          OP_FIRST, OP_LAST: begin
            n_nxt = (op_r == OP_FIRST) ? lf_r[h_r] : ll_r[h_r];
            cn_nxt[h_r] = n_nxt; cm_nxt[h_r] = MODE_ON;
            ra = n_nxt[AW-1:0];
            if (isn(n_nxt)) st_nxt = S_W1; else ost_nxt = ST_NOITEM;
          end
          OP_NEXT, OP_PREV, OP_CURR: begin
            n_nxt = NIL;
            if (op_r == OP_CURR) begin
              if (kind == MODE_ON && isn(cn_r[h_r])) n_nxt = cn_r[h_r];
            end else if (!isn(lf_r[h_r])) n_nxt = NIL;
            else if (op_r == OP_NEXT && kind == MODE_BEFORE) n_nxt = lf_r[h_r];
            else if (op_r == OP_PREV && kind == MODE_BEYOND) n_nxt = ll_r[h_r];
            if (op_r != OP_CURR && isn(lf_r[h_r]) && kind == MODE_ON) begin
              ra = cn_r[h_r][AW-1:0]; st_nxt = S_RD2;
            end else if (isn(n_nxt)) begin
              ra = n_nxt[AW-1:0]; st_nxt = S_W1;
              if (op_r != OP_CURR) begin cn_nxt[h_r] = n_nxt; cm_nxt[h_r] = MODE_ON; end
            end else begin
              ost_nxt = ST_NOITEM;
              if (op_r != OP_CURR) begin
                cn_nxt[h_r] = NIL;
                cm_nxt[h_r] = (op_r == OP_NEXT) ? MODE_BEYOND : MODE_BEFORE;
              end
            end
          end
          OP_ADD, OP_INSERT, OP_APPEND, OP_PREPEND: begin
            if (!isn(fnt_r)) ost_nxt = ST_EXHAUST;
            else begin
              n_nxt = fnt_r; ra = fnt_r[AW-1:0];
              if (!isn(lf_r[h_r])) begin p_nxt = NIL; q_nxt = NIL; st_nxt = S_W1; end
              else if (op_r == OP_APPEND || (op_r <= OP_INSERT && kind == MODE_BEYOND))
              begin p_nxt = ll_r[h_r]; q_nxt = NIL; st_nxt = S_W1; end
              else if (op_r == OP_PREPEND || kind == MODE_BEFORE)
              begin p_nxt = NIL; q_nxt = lf_r[h_r]; st_nxt = S_W1; end
              else begin
                p_nxt = cn_r[h_r]; q_nxt = cn_r[h_r]; ra = cn_r[h_r][AW-1:0];
                st_nxt = S_RD2;
              end
            end
          end
          OP_REMOVE, OP_TRIM: begin
            n_nxt = (op_r == OP_TRIM) ? ll_r[h_r] : cn_r[h_r];
            ra = n_nxt[AW-1:0];
            if (isn(n_nxt) && (op_r == OP_TRIM || kind == MODE_ON)) st_nxt = S_W1;
            else ost_nxt = ST_NOITEM;
          end
          OP_CONCAT: begin
            if (g_r != h_r) begin
              if (isn(lf_r[g_r])) begin
                if (isn(ll_r[h_r])) begin
                  wa = ll_r[h_r][AW-1:0]; we_next = 1'b1; wd_next = lf_r[g_r];
                  n_nxt = ll_r[h_r]; q_nxt = lf_r[g_r];
                  st_nxt = S_W1;
                end else lf_nxt[h_r] = lf_r[g_r];
                ll_nxt[h_r] = ll_r[g_r];
                sz_nxt[h_r] = sz_r[h_r] + sz_r[g_r];
              end
              lf_nxt[g_r] = NIL; ll_nxt[g_r] = NIL; cn_nxt[g_r] = NIL;
              cm_nxt[g_r] = MODE_ON; sz_nxt[g_r] = '0;
              fh_nxt[g_r] = fht_r; fht_nxt = HN'(g_r);
            end
          end
          OP_FREE: begin
            n_nxt = lf_r[h_r]; steps_nxt = '0; ra = n_nxt[AW-1:0];
            st_nxt = S_WALK;
          end
          default: begin
            if (kind == MODE_BEYOND || (kind == MODE_ON && !isn(cn_r[h_r]))) begin
              ost_nxt = ST_NOITEM;
            end else if (kind == MODE_BEFORE && !isn(lf_r[h_r])) begin
              cn_nxt[h_r] = NIL; cm_nxt[h_r] = MODE_ON; ost_nxt = ST_NOITEM;
            end else begin
              n_nxt = (kind == MODE_BEFORE) ? lf_r[h_r] : cn_r[h_r];
              ra = n_nxt[AW-1:0]; steps_nxt = '0; st_nxt = S_WALK;
            end
          end
        endcase
      end
      S_RD2: begin
        st_nxt = S_W1;
        if (op_r == OP_NEXT || op_r == OP_PREV) begin
          n_nxt = (op_r == OP_NEXT) ? rd_next : rd_prev;
          if (isn(n_nxt)) begin
            cn_nxt[h_r] = n_nxt; cm_nxt[h_r] = MODE_ON; ra = n_nxt[AW-1:0];
          end else begin
            cn_nxt[h_r] = NIL;
            cm_nxt[h_r] = (op_r == OP_NEXT) ? MODE_BEYOND : MODE_BEFORE;
            ost_nxt = ST_NOITEM; st_nxt = S_OUT;
          end
        end else begin
          if (op_r == OP_ADD) q_nxt = rd_next; else p_nxt = rd_prev;
          ra = fnt_r[AW-1:0];
        end
      end
      S_W1: begin
        st_nxt = S_OUT;
        case (op_r)
          OP_ADD, OP_INSERT, OP_APPEND, OP_PREPEND: begin
            fnt_nxt = rd_next;
            wa = n_r[AW-1:0]; we_item = 1'b1; we_next = 1'b1; we_prev = 1'b1;
            wd_item = v_r; wd_next = q_r; wd_prev = p_r;
            if (!isn(p_r)) lf_nxt[h_r] = n_r;
            if (!isn(q_r)) ll_nxt[h_r] = n_r;
            cn_nxt[h_r] = n_r; cm_nxt[h_r] = MODE_ON;
            sz_nxt[h_r] = sz_r[h_r] + 1'b1;
            if (isn(p_r) || isn(q_r)) st_nxt = S_W2;
          end
          OP_REMOVE, OP_TRIM: begin
            oval_nxt = 1'b1; oitem_nxt = rd_item;
            p_nxt = rd_prev; q_nxt = rd_next;
            wa = n_r[AW-1:0]; we_item = 1'b1; we_next = 1'b1; we_prev = 1'b1;
            wd_item = '0; wd_prev = NIL; wd_next = fnt_r; fnt_nxt = n_r;
            if (isn(rd_prev)) st_nxt = S_W2;
            else begin
              lf_nxt[h_r] = rd_next;
              if (isn(rd_next)) st_nxt = S_W3;
            end
            if (!isn(rd_next)) ll_nxt[h_r] = rd_prev;
            if (sz_r[h_r] != '0) sz_nxt[h_r] = sz_r[h_r] - 1'b1;
            if (op_r == OP_TRIM) begin cn_nxt[h_r] = rd_prev; cm_nxt[h_r] = MODE_ON; end
            else if (isn(rd_next)) begin cn_nxt[h_r] = rd_next; cm_nxt[h_r] = MODE_ON; end
            else if (isn(rd_prev) || isn(lf_r[h_r]) && rd_prev != NIL)
            begin cn_nxt[h_r] = NIL; cm_nxt[h_r] = MODE_BEYOND; end
            else begin cn_nxt[h_r] = NIL; cm_nxt[h_r] = MODE_ON; end
          end
          OP_CONCAT: begin
            wa = q_r[AW-1:0]; we_prev = 1'b1; wd_prev = n_r;
          end
          default: begin
            oval_nxt = 1'b1; oitem_nxt = rd_item;
          end
        endcase
      end
      S_W2: begin
        st_nxt = S_OUT;
        if (op_r == OP_REMOVE || op_r == OP_TRIM) begin
          wa = p_r[AW-1:0]; we_next = 1'b1; wd_next = q_r;
          if (isn(q_r)) st_nxt = S_W3;
        end else if (isn(p_r)) begin
          wa = p_r[AW-1:0]; we_next = 1'b1; wd_next = n_r;
          if (isn(q_r)) st_nxt = S_W3;
        end else begin
          wa = q_r[AW-1:0]; we_prev = 1'b1; wd_prev = n_r;
        end
      end
      S_W3: begin
        st_nxt = S_OUT;
        wa = q_r[AW-1:0]; we_prev = 1'b1;
        wd_prev = (op_r == OP_REMOVE || op_r == OP_TRIM) ? p_r : n_r;
      end
      S_WALK: begin
        ra = n_r[AW-1:0];
        st_nxt = S_WWAIT;
      end
      S_WWAIT: begin
        if (!isn(n_r) || steps_r == NW'(NUM_NODES)) begin
          st_nxt = S_OUT;
          if (op_r == OP_FREE) begin
            lf_nxt[h_r] = NIL; ll_nxt[h_r] = NIL; cn_nxt[h_r] = NIL;
            cm_nxt[h_r] = MODE_ON; sz_nxt[h_r] = '0;
            fh_nxt[h_r] = fht_r; fht_nxt = HN'(h_r);
          end else begin
            cn_nxt[h_r] = NIL; cm_nxt[h_r] = MODE_BEYOND; ost_nxt = ST_NOITEM;
          end
        end else if (op_r == OP_FREE) begin
          wa = n_r[AW-1:0]; we_item = 1'b1; we_next = 1'b1; we_prev = 1'b1;
          wd_item = '0; wd_prev = NIL; wd_next = fnt_r; fnt_nxt = n_r;
          n_nxt = rd_next; ra = rd_next[AW-1:0]; steps_nxt = steps_r + 1'b1;
          st_nxt = S_WALK;
        end else if (rd_item == v_r) begin
          cn_nxt[h_r] = n_r; cm_nxt[h_r] = MODE_ON;
          oval_nxt = 1'b1; oitem_nxt = rd_item; st_nxt = S_OUT;
        end else begin
          n_nxt = rd_next; ra = rd_next[AW-1:0]; steps_nxt = steps_r + 1'b1;
          st_nxt = S_WALK;
        end
      end
      S_OUT: begin
        if (out_tready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
    if (st_r != S_OUT && st_nxt == S_OUT) begin
      if (op_nxt == OP_CREATE && ost_nxt != ST_OK) ocnt_nxt = '0;
      else ocnt_nxt = sz_nxt[h_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_INIT; ic_r <= '0; fnt_r <= NW'(NUM_NODES - 1); fht_r <= HN'(NUM_LISTS - 1);
      for (int i = 0; i < NUM_LISTS; i++) begin
        lf_r[i] <= NIL; ll_r[i] <= NIL; cn_r[i] <= NIL; cm_r[i] <= MODE_ON;
        sz_r[i] <= '0; fh_r[i] <= (i == 0) ? HNIL : HN'(i - 1);
      end
    end else begin
      st_r <= st_nxt; ic_r <= ic_nxt; fnt_r <= fnt_nxt; fht_r <= fht_nxt;
      lf_r <= lf_nxt; ll_r <= ll_nxt; cn_r <= cn_nxt; cm_r <= cm_nxt;
      sz_r <= sz_nxt; fh_r <= fh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; h_r <= h_nxt; g_r <= g_nxt; v_r <= v_nxt;
    n_r <= n_nxt;
    p_r <= p_nxt; q_r <= q_nxt; steps_r <= steps_nxt;
    ost_r <= ost_nxt; oval_r <= oval_nxt; oitem_r <= oitem_nxt; ohd_r <= ohd_nxt;
    ocnt_r <= ocnt_nxt;
  end
endmodule
